FILE: design/ppt_pkg.sv
// Shared types and constants of the periodic poll timer table.
package ppt_pkg;

    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned STEP_W    = 16;
    localparam int unsigned OWNER_W   = 8;

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd100;

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_TICK     = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_INVAL = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_index;
        logic       fired;
        logic [4:0] removed_count;
        logic       last;
    } t_result;

    typedef struct packed {
        logic                 fire;
        logic [ELAPSED_W-1:0] elapsed;
    } t_tick_res;

endpackage

FILE: design/ppt_step_unit.sv
// Shared elapsed-count unit: saturating add of the tick step and compare to the interval.
module ppt_step_unit (
    input  logic [ppt_pkg::ELAPSED_W-1:0] i_elapsed,
    input  logic [ppt_pkg::ELAPSED_W-1:0] i_interval,
    input  logic [ppt_pkg::STEP_W-1:0]    i_step,
    output ppt_pkg::t_tick_res            o_res
);
    import ppt_pkg::*;

    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] sat;

    always_comb begin
        sum = {1'b0, i_elapsed} + {{(ELAPSED_W - STEP_W + 1){1'b0}}, i_step};
        sat = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];
        o_res.fire    = (sat >= i_interval);
        o_res.elapsed = o_res.fire ? '0 : sat;
    end

endmodule

FILE: design/periodic_poll_timer_table.sv
// Top level of the periodic poll timer table: sequencer, slot store and result register.
//
// Input stream: s_axis_tuser carries the request kind (register, tick, remove),
// s_axis_tdata carries interval, owner and handler flag. One request is taken at
// a time; s_axis_tready is high only while the sequencer is idle.
// Output stream: one item per result, tlast marks the final result of a request.
// A register or unknown request gives one result from the command state, which waits
// for a free output register; the sequencer then returns to idle for the next request.
// Tick and remove walk the registered slots through one slot store read port and
// one shared add/compare unit, with a read state and an execute state per slot, and
// end in a finish state that gives the final result of the request.
// A tick reports each fired slot in ascending order, or one empty result.
// The user writes the step added per tick via i_cfg_we / i_cfg_wdata while idle; not enforced.
// Reset (synchronous, active low) marks every slot inactive, clears the slot
// count and loads the tick step with 100; slot memories are not cleared.
// When the receiver stalls, the result is held in the output register and the
// walk pauses at the next result until the register drains; no result is lost.
module periodic_poll_timer_table #(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // period[31:0], owner_id[39:32], handler_present[40]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[1:0], slot_index[5:2], fired[6], removed_count[11:7]
    output logic        m_axis_tlast
);
    import ppt_pkg::*;

    localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMD  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_EX   = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [ELAPSED_W-1:0] mem_interval [NUM_SLOTS];
    logic [ELAPSED_W-1:0] mem_elapsed  [NUM_SLOTS];
    logic [OWNER_W-1:0]   mem_owner    [NUM_SLOTS];

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_req;
    logic [ELAPSED_W-1:0] r_in_interval;
    logic [OWNER_W-1:0]   r_in_owner;
    logic                 r_in_handler;
    logic [STEP_W-1:0]    r_step;
    logic [NUM_SLOTS-1:0] r_active, n_active;
    logic [CW-1:0]        r_used, n_used;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_removed, n_removed;
    logic                 r_pend_v, n_pend_v;
    logic [AW-1:0]        r_pend_idx, n_pend_idx;
    logic                 r_ovalid;
    t_result              r_out;

    logic [ELAPSED_W-1:0] r_rd_interval;
    logic [ELAPSED_W-1:0] r_rd_elapsed;
    logic [OWNER_W-1:0]   r_rd_owner;

    logic                 wr_reg;
    logic                 wr_elapsed;
    logic [AW-1:0]        wr_addr;
    logic [ELAPSED_W-1:0] wr_elapsed_data;

    logic                 out_free;
    logic                 emit_v;
    t_result              emit;
    logic                 idx_last;
    logic                 cur_active;
    t_tick_res            tick_res;

    ppt_step_unit u_step (
        .i_elapsed  (r_rd_elapsed),
        .i_interval (r_rd_interval),
        .i_step     (r_step),
        .o_res      (tick_res)
    );

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign idx_last      = (CW'(r_idx + 1'b1) == r_used);
    assign cur_active    = r_active[r_idx[AW-1:0]];

    always_comb begin
        n_state         = r_state;
        n_active        = r_active;
        n_used          = r_used;
        n_idx           = r_idx;
        n_removed       = r_removed;
        n_pend_v        = r_pend_v;
        n_pend_idx      = r_pend_idx;
        wr_reg          = 1'b0;
        wr_elapsed      = 1'b0;
        wr_addr         = r_idx[AW-1:0];
        wr_elapsed_data = tick_res.elapsed;
        emit_v          = 1'b0;
        emit            = '0;
        emit.last       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                n_idx     = '0;
                n_removed = '0;
                n_pend_v  = 1'b0;
                if (r_req == REQ_TICK || r_req == REQ_REMOVE) begin
                    n_state = (r_used == '0) ? ST_FIN : ST_RD;
                end else if (out_free) begin
                    emit_v  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_req != REQ_REGISTER) begin
                        emit.status = STATUS_INVAL;
                    end else if (r_used >= CW'(NUM_SLOTS)) begin
                        emit.status = STATUS_FULL;
                    end else if (!r_in_handler || r_in_interval == '0) begin
                        emit.status = STATUS_INVAL;
                    end else begin
                        emit.status     = STATUS_OK;
                        emit.slot_index = 4'(r_used);
                        wr_reg          = 1'b1;
                        wr_addr         = r_used[AW-1:0];
                        n_active[r_used[AW-1:0]] = 1'b1;
                        n_used          = CW'(r_used + 1'b1);
                    end
                end
            end
            ST_RD: begin
                n_state = ST_EX;
            end
            ST_EX: begin
                if (r_req == REQ_TICK) begin
                    if (cur_active && tick_res.fire) begin
                        if (!r_pend_v || out_free) begin
                            emit_v          = r_pend_v;
                            emit.slot_index = 4'(r_pend_idx);
                            emit.fired      = 1'b1;
                            emit.last       = 1'b0;
                            n_pend_v        = 1'b1;
                            n_pend_idx      = r_idx[AW-1:0];
                            wr_elapsed      = 1'b1;
                            n_idx           = CW'(r_idx + 1'b1);
                            n_state         = idx_last ? ST_FIN : ST_RD;
                        end
                    end else begin
                        wr_elapsed = cur_active;
                        n_idx      = CW'(r_idx + 1'b1);
                        n_state    = idx_last ? ST_FIN : ST_RD;
                    end
                end else begin
                    if (r_rd_owner == r_in_owner) begin
                        if (cur_active) begin
                            n_removed = CW'(r_removed + 1'b1);
                        end
                        n_active[r_idx[AW-1:0]] = 1'b0;
                    end
                    n_idx   = CW'(r_idx + 1'b1);
                    n_state = idx_last ? ST_FIN : ST_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    emit_v  = 1'b1;
                    n_state = ST_IDLE;
                    if (r_req == REQ_TICK) begin
                        emit.slot_index = r_pend_v ? 4'(r_pend_idx) : 4'd0;
                        emit.fired      = r_pend_v;
                    end else begin
                        emit.removed_count = 5'(r_removed);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= '0;
            r_used    <= '0;
            r_idx     <= '0;
            r_removed <= '0;
            r_pend_v  <= 1'b0;
            r_step    <= TICK_STEP_RESET;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_used    <= n_used;
            r_idx     <= n_idx;
            r_removed <= n_removed;
            r_pend_v  <= n_pend_v;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (emit_v) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        if (emit_v) begin
            r_out <= emit;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_req         <= s_axis_tuser;
            r_in_interval <= s_axis_tdata[31:0];
            r_in_owner    <= s_axis_tdata[39:32];
            r_in_handler  <= s_axis_tdata[40];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_reg) begin
            mem_interval[wr_addr] <= r_in_interval;
            mem_owner[wr_addr]    <= r_in_owner;
            mem_elapsed[wr_addr]  <= '0;
        end else if (wr_elapsed) begin
            mem_elapsed[wr_addr]  <= wr_elapsed_data;
        end
        r_rd_interval <= mem_interval[r_idx[AW-1:0]];
        r_rd_elapsed  <= mem_elapsed[r_idx[AW-1:0]];
        r_rd_owner    <= mem_owner[r_idx[AW-1:0]];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {4'd0, r_out.removed_count, r_out.fired, r_out.slot_index,
                            r_out.status};

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(NUM_SLOTS))
        else $error("slot count beyond table size");

    a_removed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_removed <= r_used)
        else $error("removed count beyond registered slots");

    a_read_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD |=> r_state == ST_EX)
        else $error("slot read not followed by execute");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_v |-> out_free)
        else $error("result written over a pending result");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the periodic poll timer table.
`timescale 1ns / 100ps

module tb;
    import ppt_pkg::*;

    localparam int unsigned NUM_SLOTS   = 16;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE      = 40;
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;

    class timer_table_checker;
        logic [31:0]  period[NUM_SLOTS];
        logic [31:0]  elapsed[NUM_SLOTS];
        logic [7:0]   owner_of[NUM_SLOTS];
        bit           active[NUM_SLOTS];
        int unsigned  used;
        logic [15:0]  step;
        t_result      due[$];
        int           errors;

        function new();
            foreach (active[i]) begin
                period[i]   = '0;
                elapsed[i]  = '0;
                owner_of[i] = '0;
                active[i]   = 1'b0;
            end
            used   = 0;
            step   = TICK_STEP_RESET;
            errors = 0;
        endfunction

        function void push(logic [1:0] status, logic [3:0] slot, logic fired,
                           logic [4:0] removed, logic last);
            t_result r;
            r.status        = status;
            r.slot_index    = slot;
            r.fired         = fired;
            r.removed_count = removed;
            r.last          = last;
            due.push_back(r);
        endfunction

        function void note_request(logic [1:0] kind, logic [31:0] interval,
                                   logic [7:0] owner, logic handler);
            logic [32:0] sum;
            logic [31:0] e;
            int          fires;
            int          removed;
            fires   = 0;
            removed = 0;
            case (kind)
                REQ_REGISTER: begin
                    if (used >= NUM_SLOTS) begin
                        push(STATUS_FULL, 4'd0, 1'b0, 5'd0, 1'b1);
                    end else if (!handler || interval == 32'd0) begin
                        push(STATUS_INVAL, 4'd0, 1'b0, 5'd0, 1'b1);
                    end else begin
                        period[used]   = interval;
                        elapsed[used]  = '0;
                        owner_of[used] = owner;
                        active[used]   = 1'b1;
                        push(STATUS_OK, used[3:0], 1'b0, 5'd0, 1'b1);
                        used++;
                    end
                end
                REQ_TICK: begin
                    for (int i = 0; i < used; i++) begin
                        if (active[i]) begin
                            sum = {1'b0, elapsed[i]} + {17'd0, step};
                            e   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            if (e >= period[i]) begin
                                e = '0;
                                push(STATUS_OK, i[3:0], 1'b1, 5'd0, 1'b0);
                                fires++;
                            end
                            elapsed[i] = e;
                        end
                    end
                    if (fires == 0)
                        push(STATUS_OK, 4'd0, 1'b0, 5'd0, 1'b1);
                    else
                        due[due.size()-1].last = 1'b1;
                end
                REQ_REMOVE: begin
                    for (int i = 0; i < used; i++) begin
                        if (owner_of[i] == owner) begin
                            if (active[i])
                                removed++;
                            active[i] = 1'b0;
                        end
                    end
                    push(STATUS_OK, 4'd0, 1'b0, removed[4:0], 1'b1);
                end
                default: begin
                    push(STATUS_INVAL, 4'd0, 1'b0, 5'd0, 1'b1);
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [15:0] data, logic last);
            t_result want;
            if (due.size() == 0) begin
                report($sformatf("result data=%h last=%b with nothing pending", data, last));
                return;
            end
            want = due.pop_front();
            if (data[1:0] !== want.status)
                report($sformatf("status %0d, want %0d", data[1:0], want.status));
            if (data[5:2] !== want.slot_index)
                report($sformatf("slot_index %0d, want %0d", data[5:2], want.slot_index));
            if (data[6] !== want.fired)
                report($sformatf("fired %b, want %b", data[6], want.fired));
            if (data[11:7] !== want.removed_count)
                report($sformatf("removed_count %0d, want %0d", data[11:7],
                                 want.removed_count));
            if (last !== want.last)
                report($sformatf("last %b, want %b", last, want.last));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    timer_table_checker sb = new();

    bit          steady   = 1'b0;
    bit          hold     = 1'b0;
    bit          hold_req = 1'b0;
    bit          offering = 1'b0;
    int unsigned cycles   = 0;

    periodic_poll_timer_table #(.NUM_SLOTS(NUM_SLOTS)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // check each accepted result, then pick the next ready
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (hold)
                m_axis_tready <= 1'b0;
            else if (steady)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 13);
        end
    end

    // hold off the receiver for a long stretch on request
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold <= 1'b0;
    end

    task drop_valid();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task send_request(input logic [1:0] kind, input logic [31:0] interval,
                      input logic [7:0] owner, input logic handler);
        while (!steady && $urandom_range(0, 99) < 13) begin
            drop_valid();
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, handler, owner, interval};
        offering = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(kind, interval, owner, handler);
    endtask

    task drain();
        drop_valid();
        while (sb.due.size() != 0 || !s_axis_tready) @(posedge i_clk);
    endtask

    task write_step(input logic [15:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.step = value;
    endtask

    task send_random();
        int unsigned roll;
        int unsigned base;
        logic [1:0]  kind;
        logic [31:0] interval;
        logic [7:0]  owner;
        logic        handler;
        roll     = $urandom_range(0, 99);
        base     = (sb.step == 16'd0) ? 100 : sb.step;
        interval = $urandom;
        owner    = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        handler  = $urandom_range(0, 1);
        if (roll < 25) begin
            kind    = REQ_REGISTER;
            handler = ($urandom_range(0, 99) < 90);
            if ($urandom_range(0, 99) < 85)
                interval = $urandom_range(1, 8 * base);
        end else if (roll < 82) begin
            kind = REQ_TICK;
        end else if (roll < 90) begin
            kind = REQ_REMOVE;
        end else if (roll < 95) begin
            kind = REQ_UNKNOWN;
        end else begin
            kind     = REQ_REGISTER;
            handler  = $urandom_range(0, 1);
            interval = handler ? 32'd0 : $urandom_range(1, 8 * base);
        end
        send_request(kind, interval, owner, handler);
    endtask

    initial begin
        logic [15:0] steps[5];
        steps = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 65534)), 16'd100};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_TICK,     32'd0,         8'h00, 1'b0);
        send_request(REQ_REMOVE,   32'd0,         8'h00, 1'b0);
        send_request(REQ_REGISTER, 32'd500,       8'h11, 1'b0);
        send_request(REQ_REGISTER, 32'd0,         8'h11, 1'b1);
        send_request(REQ_UNKNOWN,  32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_request(REQ_REGISTER, 32'd100,       8'h00, 1'b1);
        send_request(REQ_REGISTER, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_request(REQ_REGISTER, 32'd250,       8'hA5, 1'b1);
        send_request(REQ_REGISTER, 32'd300,       8'h5A, 1'b1);
        send_request(REQ_TICK,     32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_request(REQ_TICK,     32'd0,         8'h00, 1'b0);
        send_request(REQ_TICK,     32'd0,         8'h00, 1'b0);
        send_request(REQ_REMOVE,   32'd0,         8'hA5, 1'b0);
        send_request(REQ_REMOVE,   32'd0,         8'hA5, 1'b0);
        send_request(REQ_REGISTER, 32'd50,        8'hA5, 1'b1);
        send_request(REQ_REMOVE,   32'hFFFF_FFFF, 8'hA5, 1'b1);

        for (int p = 0; p < 5; p++) begin
            write_step(steps[p]);
            steady <= (p == 1);
            if (p == 3)
                hold_req = 1'b1;
            repeat (20) send_random();
        end
        steady <= 1'b0;

        // fill the table so every newly registered slot fires on the next tick
        write_step(16'd65535);
        while (sb.used < NUM_SLOTS)
            send_request(REQ_REGISTER, 32'd65535, 8'($urandom_range(16, 255)), 1'b1);
        send_request(REQ_REGISTER, 32'd0,   8'h33, 1'b0);
        send_request(REQ_REGISTER, 32'd700, 8'h33, 1'b1);
        send_request(REQ_TICK,     32'd0,   8'h00, 1'b0);
        send_request(REQ_TICK,     32'd0,   8'h00, 1'b0);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
design/ppt_pkg.sv
design/ppt_step_unit.sv
design/periodic_poll_timer_table.sv
test/tb.sv
